FILE: design/pbfa_pkg.sv
// pbfa_pkg: shared types, constants and helper function of the packed bit field array
// no dependencies; imported by every module of the block but pbfa_ram

package pbfa_pkg;

    localparam int STORE_WORDS = 1024;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int WORD_W      = 64;
    localparam int OFF_W       = 6;
    localparam int WIDTH_W     = 7;
    localparam int COUNT_W     = 17;
    localparam int INDEX_W     = 16;
    localparam int POS_W       = INDEX_W + WIDTH_W;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_WIDTH = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_COUNT = CFG_INDEX_W'(1);

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(8);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8192);

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic               func;
        logic [INDEX_W-1:0] index;
        logic [WORD_W-1:0]  write_value;
    } pbfa_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic              error;
    } pbfa_out_t;

    // classified request handed from front to back
    typedef struct packed {
        logic              func;
        logic              error;
        logic              straddle;
        logic [ADDR_W-1:0] addr;
        logic [OFF_W-1:0]  shift;
        logic [OFF_W-1:0]  offset;
        logic [OFF_W-1:0]  width_m1;
        logic [WORD_W-1:0] write_value;
    } pbfa_cmd_t;

    // ones in the low width_m1 + 1 bits
    function automatic logic [WORD_W-1:0] low_mask(input logic [OFF_W-1:0] width_m1);
        low_mask = {WORD_W{1'b1}} >> (~width_m1);
    endfunction

endpackage

FILE: design/pbfa_ram.sv
// pbfa_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module pbfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

FILE: design/pbfa_front.sv
// pbfa_front: accepts requests, computes word address, bit offset and checks
// depends on pbfa_pkg

module pbfa_front (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pbfa_pkg::pbfa_in_t            s_data,
    input  logic [pbfa_pkg::WIDTH_W-1:0]  element_width,
    input  logic [pbfa_pkg::COUNT_W-1:0]  element_count,
    output logic                          push_valid,
    input  logic                          push_ready,
    output pbfa_pkg::pbfa_cmd_t           push_data
);
    import pbfa_pkg::*;

    logic [POS_W-1:0]       first_pos;
    logic [POS_W-1:0]       last_pos;
    logic [POS_W-OFF_W-1:0] first_word;
    logic [POS_W-OFF_W-1:0] last_word;
    logic [WIDTH_W-1:0]     width_m1_full;
    logic [WORD_W-1:0]      mask;
    logic                   bad_width;
    logic                   bad_index;
    logic                   beyond_store;
    logic                   too_wide;

    assign first_pos  = POS_W'(s_data.index) * POS_W'(element_width);
    assign last_pos   = first_pos + POS_W'(element_width) - POS_W'(1);
    assign first_word = first_pos[POS_W-1:OFF_W];
    assign last_word  = last_pos[POS_W-1:OFF_W];

    assign width_m1_full = element_width - WIDTH_W'(1);
    assign mask          = low_mask(width_m1_full[OFF_W-1:0]);

    assign bad_width    = (element_width == '0) || (element_width > WIDTH_W'(WORD_W));
    assign bad_index    = {1'b0, s_data.index} >= element_count;
    assign beyond_store = 32'(last_word) >= 32'(STORE_WORDS);
    assign too_wide     = (s_data.func == FUNC_WRITE) && (|(s_data.write_value & ~mask));

    always_comb begin
        push_data.func        = s_data.func;
        push_data.error       = bad_width || bad_index || beyond_store || too_wide;
        push_data.straddle    = first_word != last_word;
        push_data.addr        = ADDR_W'(first_word);
        push_data.shift       = ~last_pos[OFF_W-1:0];
        push_data.offset      = first_pos[OFF_W-1:0];
        push_data.width_m1    = width_m1_full[OFF_W-1:0];
        push_data.write_value = s_data.write_value;
    end

    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

FILE: design/pbfa_queue.sv
// pbfa_queue: short fifo of classified requests between front and back
// depends on pbfa_pkg

module pbfa_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  pbfa_pkg::pbfa_cmd_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output pbfa_pkg::pbfa_cmd_t pop_data
);
    import pbfa_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pbfa_cmd_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/pbfa_back.sv
// pbfa_back: read-modify-write sequencer over the word store, plus result register
// depends on pbfa_pkg and pbfa_ram

module pbfa_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  pbfa_pkg::pbfa_cmd_t pop_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pbfa_pkg::pbfa_out_t m_data
);
    import pbfa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_A    = 2'd1;
    localparam logic [1:0] ST_B    = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    pbfa_cmd_t         cmd_reg;
    pbfa_cmd_t         cmd_next;
    logic [WORD_W-1:0] word_a_reg;
    logic [WORD_W-1:0] word_a_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    pbfa_out_t         out_reg;
    pbfa_out_t         out_next;
    logic              out_load;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;

    logic [WORD_W-1:0] mask;
    logic [ADDR_W-1:0] next_addr;
    logic [WORD_W-1:0] read_single;
    logic [WORD_W-1:0] write_single;
    logic [WORD_W-1:0] first_mask;
    logic [WORD_W-1:0] write_first;
    logic [WORD_W-1:0] write_second;
    logic [WORD_W-1:0] read_straddle;

    pbfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign mask      = low_mask(cmd_reg.width_m1);
    assign next_addr = cmd_reg.addr + ADDR_W'(1);

    // element inside one word
    assign read_single  = (ram_rd_data >> cmd_reg.shift) & mask;
    assign write_single = (ram_rd_data & ~(mask << cmd_reg.shift))
                        | (cmd_reg.write_value << cmd_reg.shift);

    // element split over two words
    assign first_mask    = {WORD_W{1'b1}} >> cmd_reg.offset;
    assign write_first   = (ram_rd_data & ~first_mask)
                         | (((cmd_reg.write_value >> 1) >> (~cmd_reg.shift)) & first_mask);
    assign write_second  = (ram_rd_data & ~({WORD_W{1'b1}} << cmd_reg.shift))
                         | (cmd_reg.write_value << cmd_reg.shift);
    assign read_straddle = (((word_a_reg << 1) << (~cmd_reg.shift))
                         | (ram_rd_data >> cmd_reg.shift)) & mask;

    assign pop_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        word_a_next    = word_a_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        out_load       = 1'b0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = cmd_reg.addr;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = cmd_reg.addr;
        ram_wr_data    = write_single;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid && pop_ready) begin
                    cmd_next = pop_data;
                    if (pop_data.error) begin
                        out_load           = 1'b1;
                        out_next.read_data = '0;
                        out_next.error     = 1'b1;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pop_data.addr;
                        state_next  = ST_A;
                    end
                end
            end
            ST_A: begin
                if (!cmd_reg.straddle) begin
                    out_load       = 1'b1;
                    out_next.error = 1'b0;
                    if (cmd_reg.func == FUNC_READ) begin
                        out_next.read_data = read_single;
                    end else begin
                        out_next.read_data = '0;
                        ram_wr_en          = 1'b1;
                        ram_wr_data        = write_single;
                    end
                    state_next = ST_IDLE;
                end else begin
                    word_a_next = ram_rd_data;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = next_addr;
                    if (cmd_reg.func == FUNC_WRITE) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = write_first;
                    end
                    state_next = ST_B;
                end
            end
            ST_B: begin
                out_load       = 1'b1;
                out_next.error = 1'b0;
                if (cmd_reg.func == FUNC_READ) begin
                    out_next.read_data = read_straddle;
                end else begin
                    out_next.read_data = '0;
                    ram_wr_en          = 1'b1;
                    ram_wr_addr        = next_addr;
                    ram_wr_data        = write_second;
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        word_a_reg <= word_a_next;
        out_reg    <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_write_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (state_reg != ST_IDLE))
        else $error("store written while idle");

    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_ready))
        else $error("pending result overwritten");

    a_second_word_straddles: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_B) |-> cmd_reg.straddle)
        else $error("second word step on a single word element");

    a_error_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready && pop_data.error) |=>
            (out_valid_reg && out_reg.error && (out_reg.read_data == '0)))
        else $error("rejected transaction not reported");
`endif

endmodule

FILE: design/packed_bit_field_array_core.sv
// packed_bit_field_array_core: top level with configuration registers
// depends on pbfa_pkg, pbfa_front, pbfa_queue and pbfa_back
//
// Use: requests enter on s_valid/s_ready/s_data (func, index, write_value) and
// one result per request leaves on m_valid/m_ready/m_data (read_data, error),
// in request order. Registers are written on cfg_valid/cfg_ready with
// cfg_index (0 element_width, 1 element_count) and cfg_data; cfg_ready is
// always high and writes to other indexes are dropped. Write them only while
// no transaction is outstanding.
// Path: each request passes through the request queue; one that fails a check
// then loads the result register directly, a single word element loads it in
// state ST_A, and one spanning two words reads its second word in ST_A and
// loads the result in ST_B, reads and writes alike. The store's one read port
// sets the throughput: the back end takes a request only while idle.
// Reset: aresetn (synchronous, active low) empties the request queue and the
// result register and restores element_width 8 and element_count 8192; the
// word store is not cleared and must be written before it is read.
// Stall: a held result stops the back end; the two entry queue then fills and
// s_ready drops until m_ready takes the result.

module packed_bit_field_array_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  pbfa_pkg::pbfa_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output pbfa_pkg::pbfa_out_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pbfa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pbfa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pbfa_pkg::*;

    logic [WIDTH_W-1:0] element_width_reg;
    logic [WIDTH_W-1:0] element_width_next;
    logic [COUNT_W-1:0] element_count_reg;
    logic [COUNT_W-1:0] element_count_next;

    logic      push_valid;
    logic      push_ready;
    pbfa_cmd_t push_data;
    logic      pop_valid;
    logic      pop_ready;
    pbfa_cmd_t pop_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        element_width_next = element_width_reg;
        element_count_next = element_count_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_ELEMENT_WIDTH) begin
                element_width_next = cfg_data[WIDTH_W-1:0];
            end else if (cfg_index == REG_ELEMENT_COUNT) begin
                element_count_next = cfg_data[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_width_reg <= WIDTH_RESET;
            element_count_reg <= COUNT_RESET;
        end else begin
            element_width_reg <= element_width_next;
            element_count_reg <= element_count_next;
        end
    end

    pbfa_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .element_width (element_width_reg),
        .element_count (element_count_reg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    pbfa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pbfa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: tb/packed_bit_field_array_checker.sv
`timescale 1ns / 100ps
// packed_bit_field_array_checker: watches the request, result and register channels,
// predicts each result from its own copy of the word store and compares field by field
// depends on pbfa_pkg; instantiated beside the block by packed_bit_field_array_core_test

module packed_bit_field_array_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  pbfa_pkg::pbfa_in_t               s_data,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  pbfa_pkg::pbfa_out_t              m_data,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [pbfa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pbfa_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatches,
    output int                               results_pending
);
    import pbfa_pkg::*;

    logic [WORD_W-1:0]  element_words [STORE_WORDS];
    logic [WIDTH_W-1:0] cur_width;
    logic [COUNT_W-1:0] cur_count;
    pbfa_out_t          results_due [$];
    pbfa_out_t          want;
    int                 results_seen;

    initial begin
        mismatches = 0;
        results_pending = 0;
        results_seen = 0;
        cur_width = WIDTH_RESET;
        cur_count = COUNT_RESET;
        foreach (element_words[i]) element_words[i] = '0;
    end

    function automatic logic [WORD_W-1:0] ones_below(input int bits);
        if (bits >= WORD_W) return '1;
        return (WORD_W'(1) << bits) - WORD_W'(1);
    endfunction

    // applies a request to the word store copy and returns its result
    function automatic pbfa_out_t predict_element(input pbfa_in_t req);
        pbfa_out_t         res;
        logic [WORD_W-1:0] mask, first_bit, last_bit, hi, lo, m1;
        logic [ADDR_W-1:0] wa, wb;
        int                w, off, n2, sh;
        res = '0;
        w = int'(cur_width);
        if (w == 0 || w > WORD_W || req.index >= cur_count) begin
            res.error = 1'b1;
            return res;
        end
        first_bit = WORD_W'(req.index) * WORD_W'(w);
        last_bit = first_bit + WORD_W'(w - 1);
        mask = ones_below(w);
        if ((last_bit >> OFF_W) >= STORE_WORDS) res.error = 1'b1;
        if (req.func == FUNC_WRITE && (req.write_value & ~mask) != '0) res.error = 1'b1;
        if (res.error) return res;
        wa = ADDR_W'(first_bit >> OFF_W);
        wb = ADDR_W'(last_bit >> OFF_W);
        off = int'(first_bit[OFF_W-1:0]);
        if (wa == wb) begin
            sh = WORD_W - off - w;
            if (req.func == FUNC_READ) begin
                res.read_data = (element_words[wa] >> sh) & mask;
            end else begin
                element_words[wa] = (element_words[wa] & ~(mask << sh))
                                    | (req.write_value << sh);
            end
        end else begin
            // element spans two words: upper part ends word wa, lower part starts word wb
            n2 = int'(last_bit[OFF_W-1:0]) + 1;
            m1 = ones_below(WORD_W - off);
            if (req.func == FUNC_READ) begin
                hi = element_words[wa] & m1;
                lo = element_words[wb] >> (WORD_W - n2);
                res.read_data = ((hi << n2) | lo) & mask;
            end else begin
                hi = (req.write_value >> n2) & m1;
                lo = req.write_value << (WORD_W - n2);
                element_words[wa] = (element_words[wa] & ~m1) | hi;
                element_words[wb] = (element_words[wb] & ones_below(WORD_W - n2)) | lo;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] exp_value);
        $display("mismatch on %s of result %0d: got %h, expected %h",
                 what, results_seen, got, exp_value);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_width = WIDTH_RESET;
            cur_count = COUNT_RESET;
            results_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected transaction", m_data.read_data, '0);
                end else begin
                    want = results_due.pop_front();
                    if (m_data.error !== want.error)
                        report_mismatch("error", WORD_W'(m_data.error), WORD_W'(want.error));
                    if (m_data.read_data !== want.read_data)
                        report_mismatch("read_data", m_data.read_data, want.read_data);
                end
            end
            if (s_valid && s_ready) results_due.push_back(predict_element(s_data));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ELEMENT_WIDTH: cur_width = cfg_data[WIDTH_W-1:0];
                    REG_ELEMENT_COUNT: cur_count = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
        results_pending = results_due.size();
    end

endmodule

FILE: tb/packed_bit_field_array_core_test.sv
`timescale 1ns / 100ps
// packed_bit_field_array_core_test: clock, reset, request and register stimulus and verdict
// depends on pbfa_pkg, packed_bit_field_array_core and packed_bit_field_array_checker

module packed_bit_field_array_core_test;
    import pbfa_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PLAN_COUNT     = 13;

    typedef struct packed {
        int width;
        int count;
        int hot_lo;
        int hot_hi;
        int items;
        bit gaps;
    } setting_plan_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    pbfa_in_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    pbfa_out_t              m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     results_pending;

    logic [WORD_W-1:0]      known_bits [STORE_WORDS];
    setting_plan_t          plans [PLAN_COUNT];
    int                     cur_width;
    int                     cur_count;
    bit                     gaps_on;
    int                     idle_cycles = 0;
    int                     stall_left = 0;
    int                     writes_sent;
    int                     reads_sent;
    int                     reg_writes;

    packed_bit_field_array_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    packed_bit_field_array_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready = 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic bit element_in_store(input int idx);
        longint last_bit;
        if (cur_width < 1 || cur_width > WORD_W || idx >= cur_count) return 1'b0;
        last_bit = longint'(idx) * cur_width + cur_width - 1;
        return (last_bit >> OFF_W) < STORE_WORDS;
    endfunction

    function automatic bit value_fits(input logic [WORD_W-1:0] val);
        return cur_width >= WORD_W || (val >> cur_width) == '0;
    endfunction

    task automatic issue(input logic func, input int idx, input logic [WORD_W-1:0] val);
        pbfa_in_t req;
        int       p;
        req.func = func;
        req.index = idx[INDEX_W-1:0];
        req.write_value = val;
        if (func == FUNC_WRITE) begin
            writes_sent++;
            // bits that a successful write defines may be read back later
            if (element_in_store(idx) && value_fits(val)) begin
                for (p = idx * cur_width; p < (idx + 1) * cur_width; p++)
                    known_bits[p / WORD_W][WORD_W - 1 - p % WORD_W] = 1'b1;
            end
        end else begin
            reads_sent++;
        end
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] reg_index,
                           input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        s_valid = 1'b0;
        while (results_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = reg_index;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        case (reg_index)
            REG_ELEMENT_WIDTH: cur_width = int'(value[WIDTH_W-1:0]);
            REG_ELEMENT_COUNT: cur_count = int'(value[COUNT_W-1:0]);
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic configure(input int w, input int c);
        set_reg(REG_ELEMENT_WIDTH, ($urandom << WIDTH_W) | CFG_DATA_W'(w));
        if ($urandom_range(0, 2) == 0) set_reg(CFG_INDEX_W'($urandom_range(2, 15)), $urandom);
        set_reg(REG_ELEMENT_COUNT, ($urandom << COUNT_W) | CFG_DATA_W'(c));
    endtask

    task automatic run_setting(input setting_plan_t plan);
        int                n, r, idx, p;
        logic              func;
        logic [WORD_W-1:0] val, mask;
        configure(plan.width, plan.count);
        gaps_on = plan.gaps;
        if (cur_width >= 1 && cur_width < WORD_W) mask = (WORD_W'(1) << cur_width) - 1;
        else mask = '1;
        for (n = 0; n < plan.items; n++) begin
            r = $urandom_range(0, 99);
            if (r < 70) idx = $urandom_range(plan.hot_lo, plan.hot_hi);
            else if (r < 80) idx = cur_count - 2 + $urandom_range(0, 3);
            else if (r < 90)
                idx = (cur_width > 0 ? STORE_WORDS * WORD_W / cur_width : 0)
                      - 2 + $urandom_range(0, 3);
            else idx = $urandom_range(0, 65535);
            idx = idx & 16'hffff;
            func = ($urandom_range(0, 1) == 1) ? FUNC_WRITE : FUNC_READ;
            // an element with undefined bits is written instead of read
            if (func == FUNC_READ && element_in_store(idx)) begin
                for (p = idx * cur_width; p < (idx + 1) * cur_width; p++)
                    if (!known_bits[p / WORD_W][WORD_W - 1 - p % WORD_W]) func = FUNC_WRITE;
            end
            val = {$urandom, $urandom};
            r = $urandom_range(0, 99);
            if (func == FUNC_WRITE && cur_width >= 1 && cur_width <= WORD_W) begin
                if (r < 10) val = mask;
                else if (r < 20) val = '0;
                else if (r < 88 || cur_width == WORD_W) val = val & mask;
                else val = val | (WORD_W'(1) << $urandom_range(cur_width, WORD_W - 1));
            end
            issue(func, idx, val);
        end
    endtask

    initial begin
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_ready = 1'b0;
        aresetn = 1'b0;
        gaps_on = 1'b1;
        writes_sent = 0;
        reads_sent = 0;
        reg_writes = 0;
        cur_width = int'(WIDTH_RESET);
        cur_count = int'(COUNT_RESET);
        foreach (known_bits[i]) known_bits[i] = '0;
        plans = '{
            '{8,   8192,   0,    63,   120, 1'b1},
            '{1,   65536,  0,    200,  120, 1'b1},
            '{64,  65536,  1000, 1023, 120, 1'b1},
            '{13,  300,    0,    60,   130, 1'b1},
            '{63,  40,     0,    39,   120, 1'b1},
            '{0,   100,    0,    99,   30,  1'b1},
            '{100, 100,    0,    99,   30,  1'b1},
            '{33,  1,      0,    1,    60,  1'b1},
            '{17,  131071, 3800, 3860, 120, 1'b1},
            '{5,   0,      0,    20,   30,  1'b1},
            '{64,  200,    0,    199,  140, 1'b1},
            '{2,   65536,  0,    300,  150, 1'b0},
            '{7,   500,    0,    120,  130, 1'b0}
        };
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        issue(FUNC_WRITE, 0, 64'hA5);
        issue(FUNC_READ, 0, '1);
        issue(FUNC_WRITE, 8191, 64'hFF);
        issue(FUNC_READ, 8191, '0);
        issue(FUNC_READ, 8192, '0);
        issue(FUNC_WRITE, 3, 64'h100);
        issue(FUNC_WRITE, 65535, '0);
        configure(64, 65536);
        issue(FUNC_WRITE, 1023, '1);
        issue(FUNC_READ, 1023, '0);
        issue(FUNC_WRITE, 1024, 64'h5);
        issue(FUNC_READ, 65535, '0);
        issue(FUNC_WRITE, 0, 64'h8000_0000_0000_0001);
        issue(FUNC_READ, 0, '0);
        set_reg(REG_ELEMENT_WIDTH, 13);
        issue(FUNC_WRITE, 4, 64'h1FFF);
        issue(FUNC_READ, 4, '0);
        issue(FUNC_WRITE, 5, 64'hAAA);
        issue(FUNC_READ, 5, '0);
        issue(FUNC_READ, 4, '0);
        set_reg(REG_ELEMENT_WIDTH, 32'h80);
        issue(FUNC_READ, 0, '0);
        set_reg(REG_ELEMENT_WIDTH, 127);
        issue(FUNC_WRITE, 0, '0);
        configure(1, 1);
        issue(FUNC_READ, 1, '0);
        issue(FUNC_WRITE, 0, 64'h1);
        issue(FUNC_READ, 0, '0);

        foreach (plans[i]) run_setting(plans[i]);

        @(negedge aclk);
        s_valid = 1'b0;
        while (results_pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        $display("sent %0d transactions (%0d writes, %0d reads) through %0d register writes,",
                 writes_sent + reads_sent, writes_sent, reads_sent, reg_writes);
        $display("covering element widths 1 to 64, invalid widths, empty and full counts");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
